FILE: rtl/core/key_click_double_long_detector_defines.svh
// assertion macros used by the top-level rtl file
`ifndef KEY_CLICK_DOUBLE_LONG_DETECTOR_DEFINES_SVH
`define KEY_CLICK_DOUBLE_LONG_DETECTOR_DEFINES_SVH

`ifndef SYNTH
`define KCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kcd assertion failed");
`define KCD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("kcd assertion failed");
`else
`define KCD_ASSERT(lbl, prop)
`define KCD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/core/kcd_pkg.sv
package kcd_pkg;

    localparam int NUM_KEYS   = 6;
    localparam int PIN_W      = 6;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 16;
    localparam int KEY_IDX_W  = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [THR_W-1:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [THR_W-1:0] DBL_WINDOW_RESET = 16'd300;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW = 1'd1;

    localparam logic [1:0] TALLY_MAX = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_MERGE = 2'd2
    } t_state;

    typedef struct packed {
        t_phase              phase;
        logic [TIME_W-1:0]   mark;
        logic [1:0]          tally;
    } t_key_state;

    typedef struct packed {
        t_key_state nxt;
        t_event     kind;
    } t_lane_res;

endpackage

FILE: rtl/core/kcd_lane.sv
module kcd_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  kcd_pkg::t_key_state            i_key,
    input  logic                           i_down,
    input  logic [kcd_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [kcd_pkg::THR_W-1:0]      i_long_press_ms,
    input  logic [kcd_pkg::THR_W-1:0]      i_window_ms,
    output kcd_pkg::t_lane_res             o_res
);

    kcd_pkg::t_lane_res              r_res;
    kcd_pkg::t_lane_res              n_res;
    logic [kcd_pkg::TIME_W-1:0]      elapsed;
    logic                            long_hit;
    logic                            window_hit;

    assign elapsed    = i_now_ms - i_key.mark;
    assign long_hit   = elapsed > {{(kcd_pkg::TIME_W-kcd_pkg::THR_W){1'b0}}, i_long_press_ms};
    assign window_hit = elapsed > {{(kcd_pkg::TIME_W-kcd_pkg::THR_W){1'b0}}, i_window_ms};

    always_comb begin
        n_res.nxt  = i_key;
        n_res.kind = kcd_pkg::EV_NONE;
        case (i_key.phase)
            kcd_pkg::PH_PRESSED: begin
                if (!i_down) begin
                    n_res.nxt.phase = kcd_pkg::PH_RELEASED;
                    n_res.nxt.mark  = i_now_ms;
                    if (i_key.tally != kcd_pkg::TALLY_MAX) begin
                        n_res.nxt.tally = i_key.tally + 2'd1;
                    end
                end else if (long_hit) begin
                    n_res.nxt.phase = kcd_pkg::PH_IDLE;
                    n_res.nxt.tally = 2'd0;
                    n_res.kind      = kcd_pkg::EV_LONG;
                end
            end
            kcd_pkg::PH_RELEASED: begin
                if (i_down) begin
                    n_res.nxt.phase = kcd_pkg::PH_PRESSED;
                    n_res.nxt.mark  = i_now_ms;
                end else if (window_hit) begin
                    n_res.nxt.phase = kcd_pkg::PH_IDLE;
                    n_res.nxt.tally = 2'd0;
                    if (i_key.tally == 2'd1) begin
                        n_res.kind = kcd_pkg::EV_SINGLE;
                    end else if (i_key.tally == 2'd2) begin
                        n_res.kind = kcd_pkg::EV_DOUBLE;
                    end
                end
            end
            default: begin
                n_res.nxt.phase = kcd_pkg::PH_IDLE;
                if (i_down) begin
                    n_res.nxt.phase = kcd_pkg::PH_PRESSED;
                    n_res.nxt.mark  = i_now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/core/kcd_merge.sv
module kcd_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_commit,
    input  kcd_pkg::t_lane_res               i_lane [kcd_pkg::NUM_KEYS],
    output kcd_pkg::t_key_state              o_keys [kcd_pkg::NUM_KEYS],
    output kcd_pkg::t_event                  o_kind,
    output logic [kcd_pkg::KEY_IDX_W-1:0]    o_key_id
);

    kcd_pkg::t_key_state            r_keys [kcd_pkg::NUM_KEYS];
    kcd_pkg::t_key_state            n_keys [kcd_pkg::NUM_KEYS];
    kcd_pkg::t_event                kind;
    logic [kcd_pkg::KEY_IDX_W-1:0]  who;
    logic                           blocked;

    // first firing key wins, later keys keep their state
    always_comb begin
        kind    = kcd_pkg::EV_NONE;
        who     = '0;
        blocked = 1'b0;
        for (int k = 0; k < kcd_pkg::NUM_KEYS; k++) begin
            n_keys[k] = r_keys[k];
            if (!blocked) begin
                n_keys[k] = i_lane[k].nxt;
                if (i_lane[k].kind != kcd_pkg::EV_NONE) begin
                    kind    = i_lane[k].kind;
                    who     = kcd_pkg::KEY_IDX_W'(k);
                    blocked = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < kcd_pkg::NUM_KEYS; k++) begin
            if (!i_rst_n) begin
                r_keys[k].phase <= kcd_pkg::PH_IDLE;
                r_keys[k].mark  <= '0;
                r_keys[k].tally <= 2'd0;
            end else if (i_commit) begin
                r_keys[k] <= n_keys[k];
            end
        end
    end

    assign o_keys   = r_keys;
    assign o_kind   = kind;
    assign o_key_id = who;

endmodule

FILE: rtl/core/key_click_double_long_detector.sv
// Detects single clicks, double clicks and long presses on six active-low
// keys. Each input item is one scan (pin levels plus the millisecond time);
// each scan yields exactly one result item: the event found and the key
// that caused it, or no event with key number 0. Keys are evaluated in
// parallel lanes and the lowest-index key that fires wins; keys above it
// keep their state for the next scan. An accepted scan is registered, the
// lanes register their results in the EVAL state and the merged result is
// committed to the result register in the MERGE state; the input is ready
// again once the result is committed, so no new scan is taken before then.
// While an earlier result is still waiting, the commit holds until it is
// taken. The user must write thresholds through the config port only while
// the block is idle; the block itself does not enforce this.
`include "key_click_double_long_detector_defines.svh"

module key_click_double_long_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [kcd_pkg::PIN_W-1:0]         i_pin_levels,
    input  logic [kcd_pkg::TIME_W-1:0]        i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_event_kind,
    output logic [kcd_pkg::KEY_IDX_W-1:0]     o_key_id,
    input  logic                              i_cfg_we,
    input  logic [kcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kcd_pkg::THR_W-1:0]         i_cfg_data
);

    kcd_pkg::t_state                  r_state;
    kcd_pkg::t_state                  n_state;
    logic [kcd_pkg::PIN_W-1:0]        r_pins;
    logic [kcd_pkg::TIME_W-1:0]       r_now;
    logic [kcd_pkg::THR_W-1:0]        r_long_press_ms;
    logic [kcd_pkg::THR_W-1:0]        r_window_ms;
    logic                             r_out_valid;
    kcd_pkg::t_event                  r_kind;
    logic [kcd_pkg::KEY_IDX_W-1:0]    r_key_id;

    logic                             in_accept;
    logic                             lane_en;
    logic                             commit;
    logic [kcd_pkg::NUM_KEYS-1:0]     down;
    kcd_pkg::t_lane_res               lane_res [kcd_pkg::NUM_KEYS];
    kcd_pkg::t_key_state              keys     [kcd_pkg::NUM_KEYS];
    kcd_pkg::t_event                  merge_kind;
    logic [kcd_pkg::KEY_IDX_W-1:0]    merge_idx;

    assign in_accept = i_in_valid && o_in_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= kcd_pkg::LONG_PRESS_RESET;
            r_window_ms     <= kcd_pkg::DBL_WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kcd_pkg::REG_LONG_PRESS: r_long_press_ms <= i_cfg_data;
                kcd_pkg::REG_DBL_WINDOW: r_window_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kcd_pkg::S_IDLE:  if (in_accept) n_state = kcd_pkg::S_EVAL;
            kcd_pkg::S_EVAL:  n_state = kcd_pkg::S_MERGE;
            kcd_pkg::S_MERGE: if (!r_out_valid || i_out_ready) n_state = kcd_pkg::S_IDLE;
            default:          n_state = kcd_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        lane_en    = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            kcd_pkg::S_IDLE:  o_in_ready = 1'b1;
            kcd_pkg::S_EVAL:  lane_en    = 1'b1;
            kcd_pkg::S_MERGE: commit     = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pins <= i_pin_levels;
            r_now  <= i_now_ms;
        end
    end

    // keys beyond the pin field read as pressed
    for (genvar k = 0; k < kcd_pkg::NUM_KEYS; k++) begin : g_lane
        if (k < kcd_pkg::PIN_W) begin : g_pin
            assign down[k] = ~r_pins[k];
        end else begin : g_nopin
            assign down[k] = 1'b1;
        end

        kcd_lane u_lane (
            .i_clk           (i_clk),
            .i_en            (lane_en),
            .i_key           (keys[k]),
            .i_down          (down[k]),
            .i_now_ms        (r_now),
            .i_long_press_ms (r_long_press_ms),
            .i_window_ms     (r_window_ms),
            .o_res           (lane_res[k])
        );
    end

    kcd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (commit),
        .i_lane      (lane_res),
        .o_keys      (keys),
        .o_kind      (merge_kind),
        .o_key_id    (merge_idx)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_kind   <= merge_kind;
            r_key_id <= merge_idx;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_key_id     = r_key_id;

    `KCD_ASSERT(a_none_key0, o_out_valid && (o_event_kind == kcd_pkg::EV_NONE) |-> o_key_id == '0)
    `KCD_ASSERT(a_accept_busy, in_accept |=> !o_in_ready ##1 !o_in_ready)
    `KCD_ASSERT(a_merge_fills, (r_state == kcd_pkg::S_MERGE) && !r_out_valid |=> o_out_valid)
    `KCD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && o_in_ready)

endmodule
